@@ design/transform_coefficient_dequantizer_core_macros.svh @@
// Assertion macros shared by the dequantizer core.
`ifndef TRANSFORM_COEFFICIENT_DEQUANTIZER_CORE_MACROS_SVH
`define TRANSFORM_COEFFICIENT_DEQUANTIZER_CORE_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define TCDQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante holds.
`define TCDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tcdq_pkg.sv @@
// Package: widths, constants, types and tables of the coefficient dequantizer.
package tcdq_pkg;

	localparam int CoeffW   = 16;
	localparam int ScaleW   = 8;
	localparam int QpInW    = 7;
	localparam int Log2W    = 3;
	localparam int ResW     = 21;
	localparam int QpW      = 7;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 6;

	localparam int BdW      = 5;
	localparam int RngW     = 5;
	localparam int OffW     = 6;
	localparam int SkipW    = 4;

	localparam int ExpW     = 5;
	localparam int RemW     = 3;
	localparam int ShiftW   = 6;
	localparam int DiffW    = 7;
	localparam int LvlW     = 7;
	localparam int LsW      = LvlW + ScaleW;
	localparam int ProdW    = 31;
	localparam int AccW     = 53;
	localparam int RshW     = 34;
	localparam int RshMax   = 32;

	localparam int QpMaxBase    = 63;
	localparam int ShiftBase    = 10;
	localparam int ActLumaAdj   = -5;
	localparam int ActChromaAdj = 1;
	localparam int TsMinBase    = 4;
	localparam int TsMinStep    = 6;
	localparam int QpPeriod     = 6;
	localparam int RngMax       = 20;
	localparam int Div6Mul      = 43;
	localparam int Div6Sh       = 8;
	localparam int Div6ProdW    = QpW + 6;

	localparam logic [CfgIdxW-1:0] CfgSampleBitDepth = 3'd0;
	localparam logic [CfgIdxW-1:0] CfgCoeffRangeLog2 = 3'd1;
	localparam logic [CfgIdxW-1:0] CfgQpDepthOffset  = 3'd2;
	localparam logic [CfgIdxW-1:0] CfgSkipMinQpCode  = 3'd3;
	localparam logic [CfgIdxW-1:0] CfgDepQuantEnable = 3'd4;

	typedef struct packed {
		logic [BdW-1:0]   sample_bit_depth;
		logic [RngW-1:0]  coeff_range_log2;
		logic [OffW-1:0]  qp_depth_offset;
		logic [SkipW-1:0] skip_min_qp_code;
		logic             dep_quant_enabled;
	} cfg_t;

	typedef struct packed {
		logic signed [CoeffW-1:0] coeff;
		logic [ScaleW-1:0]        scale_factor;
		logic signed [QpInW-1:0]  qp_in;
		logic                     is_chroma;
		logic                     transform_skip;
		logic                     act_enabled;
		logic [Log2W-1:0]         log2_width;
		logic [Log2W-1:0]         log2_height;
	} item_t;

	// qp stage to multiply stage
	typedef struct packed {
		logic                     valid;
		logic signed [CoeffW-1:0] coeff;
		logic [ScaleW-1:0]        scale_factor;
		logic [QpW-1:0]           qp_used;
		logic [ExpW-1:0]          expo;
		logic [RemW-1:0]          rem;
		logic                     rect;
		logic [ShiftW-1:0]        shift;
	} qp_bus_t;

	// multiply stage to rounding stage
	typedef struct packed {
		logic                    valid;
		logic signed [ProdW-1:0] prod;
		logic signed [DiffW-1:0] diff;
		logic [QpW-1:0]          qp_used;
	} mul_bus_t;

	typedef struct packed {
		logic                   valid;
		logic signed [ResW-1:0] scaled_coeff;
		logic [QpW-1:0]         qp_used;
	} res_t;

	function automatic logic [LvlW-1:0] lvl_scale(input logic rect, input logic [RemW-1:0] rem);
		logic [LvlW-1:0] v;
		case ({rect, rem})
			4'b0_000: v = 7'd40;
			4'b0_001: v = 7'd45;
			4'b0_010: v = 7'd51;
			4'b0_011: v = 7'd57;
			4'b0_100: v = 7'd64;
			4'b0_101: v = 7'd72;
			4'b1_000: v = 7'd57;
			4'b1_001: v = 7'd64;
			4'b1_010: v = 7'd72;
			4'b1_011: v = 7'd80;
			4'b1_100: v = 7'd90;
			4'b1_101: v = 7'd102;
			default:  v = '0;
		endcase
		return v;
	endfunction

	// Clip range above the output field saturates to the field.
	function automatic logic [RngW-1:0] clip_rng(input logic [RngW-1:0] crl);
		return (crl > RngW'(RngMax)) ? RngW'(RngMax) : crl;
	endfunction

endpackage

@@ design/tcdq_if.sv @@
// Channel interfaces: coefficient input, result output, configuration write.
interface tcdq_in_if
	import tcdq_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic signed [CoeffW-1:0] coeff;
	logic [ScaleW-1:0]        scale_factor;
	logic signed [QpInW-1:0]  qp_in;
	logic                     is_chroma;
	logic                     transform_skip;
	logic                     act_enabled;
	logic [Log2W-1:0]         log2_width;
	logic [Log2W-1:0]         log2_height;

	modport source (output valid, coeff, scale_factor, qp_in, is_chroma, transform_skip,
		act_enabled, log2_width, log2_height, input ready);
	modport sink (input valid, coeff, scale_factor, qp_in, is_chroma, transform_skip,
		act_enabled, log2_width, log2_height, output ready);
endinterface

interface tcdq_out_if
	import tcdq_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic signed [ResW-1:0] scaled_coeff;
	logic [QpW-1:0]         qp_used;

	modport source (output valid, scaled_coeff, qp_used, input ready);
	modport sink (input valid, scaled_coeff, qp_used, output ready);
endinterface

interface tcdq_cfg_if
	import tcdq_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [CfgIdxW-1:0]  index;
	logic [CfgDataW-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ design/tcdq_qp.sv @@
// Stages 1-2: effective qp, clipping, shift, and qp split into exponent and remainder.
module tcdq_qp
	import tcdq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    adv,
	input  cfg_t    cfg,
	input  logic    in_valid,
	input  item_t   item,
	output qp_bus_t bus
);

	logic signed [7:0]  qp_base;
	logic signed [7:0]  qp_adj;
	logic [QpW-1:0]     qmax;
	logic [QpW-1:0]     qmin;
	logic [QpW-1:0]     qp_cl;
	logic [Log2W:0]     sum;
	logic               rect;
	logic signed [7:0]  sh_raw;
	logic [ShiftW-1:0]  shift;
	logic [QpW-1:0]     q;

	logic                     v_s1;
	logic signed [CoeffW-1:0] coeff_s1;
	logic [ScaleW-1:0]        scale_s1;
	logic [QpW-1:0]           qp_s1;
	logic [QpW-1:0]           q_s1;
	logic                     rect_s1;
	logic [ShiftW-1:0]        shift_s1;

	logic [Div6ProdW-1:0] div_prod;
	logic [ExpW-1:0]      expo;
	logic [QpW-1:0]       rem_full;

	logic                     v_s2;
	logic signed [CoeffW-1:0] coeff_s2;
	logic [ScaleW-1:0]        scale_s2;
	logic [QpW-1:0]           qp_s2;
	logic [ExpW-1:0]          expo_s2;
	logic [RemW-1:0]          rem_s2;
	logic                     rect_s2;
	logic [ShiftW-1:0]        shift_s2;

	always_comb begin
		qp_base = $signed({item.qp_in[QpInW-1], item.qp_in});
		if (!item.is_chroma) begin
			qp_base = qp_base + $signed({2'b00, cfg.qp_depth_offset});
		end
		qp_adj = qp_base;
		if (item.act_enabled) begin
			if (item.is_chroma) begin
				qp_adj = qp_base + $signed(8'(ActChromaAdj));
			end else begin
				qp_adj = qp_base + $signed(8'(ActLumaAdj));
			end
		end

		qmax = QpW'(QpMaxBase) + {1'b0, cfg.qp_depth_offset};
		if (item.transform_skip) begin
			qmin = QpW'(TsMinBase) + QpW'(TsMinStep) * {3'b000, cfg.skip_min_qp_code};
		end else begin
			qmin = '0;
		end

		// lower bound wins when the bounds cross
		if (qp_adj < $signed({1'b0, qmin})) begin
			qp_cl = qmin;
		end else if (qp_adj > $signed({1'b0, qmax})) begin
			qp_cl = qmax;
		end else begin
			qp_cl = qp_adj[QpW-1:0];
		end

		sum  = {1'b0, item.log2_width} + {1'b0, item.log2_height};
		rect = !item.transform_skip && sum[0];

		sh_raw = $signed({3'b000, cfg.sample_bit_depth}) + $signed({7'b0, rect})
			+ $signed({5'b0, sum[Log2W:1]}) + $signed(8'(ShiftBase))
			- $signed({3'b000, cfg.coeff_range_log2}) + $signed({7'b0, cfg.dep_quant_enabled});
		if (item.transform_skip) begin
			shift = ShiftW'(ShiftBase);
		end else if (sh_raw < 0) begin
			shift = '0;
		end else begin
			shift = sh_raw[ShiftW-1:0];
		end

		q = qp_cl + {6'b0, cfg.dep_quant_enabled && !item.transform_skip};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// q div 6 by reciprocal multiply, exact over the 7-bit range
	always_comb begin
		div_prod = Div6ProdW'(q_s1) * Div6ProdW'(Div6Mul);
		expo     = div_prod[Div6Sh +: ExpW];
		rem_full = q_s1 - QpW'(expo) * QpW'(QpPeriod);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coeff_s1 <= item.coeff;
			scale_s1 <= item.scale_factor;
			qp_s1    <= qp_cl;
			q_s1     <= q;
			rect_s1  <= rect;
			shift_s1 <= shift;

			coeff_s2 <= coeff_s1;
			scale_s2 <= scale_s1;
			qp_s2    <= qp_s1;
			expo_s2  <= expo;
			rem_s2   <= rem_full[RemW-1:0];
			rect_s2  <= rect_s1;
			shift_s2 <= shift_s1;
		end
	end

	assign bus.valid        = v_s2;
	assign bus.coeff        = coeff_s2;
	assign bus.scale_factor = scale_s2;
	assign bus.qp_used      = qp_s2;
	assign bus.expo         = expo_s2;
	assign bus.rem          = rem_s2;
	assign bus.rect         = rect_s2;
	assign bus.shift        = shift_s2;

endmodule

@@ design/tcdq_mul.sv @@
// Stages 3-4: level-scale lookup, scale products and net shift.
module tcdq_mul
	import tcdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  qp_bus_t  qb,
	output mul_bus_t mb
);

	logic [LvlW-1:0]          lvl;
	logic                     v_s3;
	logic signed [CoeffW-1:0] coeff_s3;
	logic [LsW-1:0]           ls_s3;
	logic signed [DiffW-1:0]  diff_s3;
	logic [QpW-1:0]           qp_s3;

	logic signed [31:0]       prod_full;
	logic                     v_s4;
	logic signed [ProdW-1:0]  prod_s4;
	logic signed [DiffW-1:0]  diff_s4;
	logic [QpW-1:0]           qp_s4;

	assign lvl = lvl_scale(qb.rect, qb.rem);

	always_comb begin
		prod_full = $signed(coeff_s3) * $signed({1'b0, ls_s3});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= qb.valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coeff_s3 <= qb.coeff;
			ls_s3    <= LsW'(lvl) * LsW'(qb.scale_factor);
			// rounding shift minus exponent of the level scale
			diff_s3  <= $signed({1'b0, qb.shift}) - $signed({2'b00, qb.expo});
			qp_s3    <= qb.qp_used;

			prod_s4  <= prod_full[ProdW-1:0];
			diff_s4  <= diff_s3;
			qp_s4    <= qp_s3;
		end
	end

	assign mb.valid   = v_s4;
	assign mb.prod    = prod_s4;
	assign mb.diff    = diff_s4;
	assign mb.qp_used = qp_s4;

endmodule

@@ design/tcdq_round.sv @@
// Stages 5-6: rounding shift and clip to the coefficient range; stage 6 is the output register.
module tcdq_round
	import tcdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  cfg_t     cfg,
	input  mul_bus_t mb,
	output res_t     res
);

	logic                   d_le0;
	logic [DiffW-1:0]       neg_d;
	logic [ExpW-1:0]        lsh;
	logic [ShiftW-1:0]      rsh_amt;
	logic [ShiftW-1:0]      rsh_m1;
	logic signed [AccW-1:0] m_wide;
	logic signed [AccW-1:0] shl;
	logic signed [RshW-1:0] m_mid;
	logic signed [RshW-1:0] rnd;
	logic signed [RshW-1:0] rsh;
	logic signed [AccW-1:0] val;

	logic                   v_s5;
	logic signed [AccW-1:0] acc_s5;
	logic [QpW-1:0]         qp_s5;

	logic [RngW-1:0]        rng;
	logic signed [AccW-1:0] hi;
	logic signed [AccW-1:0] lo;
	logic signed [AccW-1:0] clipped;

	logic                   v_s6;
	logic signed [ResW-1:0] scaled_s6;
	logic [QpW-1:0]         qp_s6;

	always_comb begin
		d_le0  = (mb.diff <= 0);
		neg_d  = DiffW'(-mb.diff);
		lsh    = neg_d[ExpW-1:0];
		m_wide = $signed({{(AccW-ProdW){mb.prod[ProdW-1]}}, mb.prod});
		shl    = m_wide <<< lsh;

		// past 32 the rounded result is 0 for any product
		if (mb.diff > $signed(DiffW'(RshMax))) begin
			rsh_amt = ShiftW'(RshMax);
		end else begin
			rsh_amt = mb.diff[ShiftW-1:0];
		end
		rsh_m1 = rsh_amt - 6'd1;
		m_mid  = $signed({{(RshW-ProdW){mb.prod[ProdW-1]}}, mb.prod});
		rnd    = $signed(RshW'(1) << rsh_m1);
		rsh    = (m_mid + rnd) >>> rsh_amt;

		if (d_le0) begin
			val = shl;
		end else begin
			val = $signed({{(AccW-RshW){rsh[RshW-1]}}, rsh});
		end
	end

	always_comb begin
		rng = clip_rng(cfg.coeff_range_log2);
		hi  = $signed(AccW'(1) << rng) - $signed(AccW'(1));
		lo  = -$signed(AccW'(1) << rng);
		if (acc_s5 < lo) begin
			clipped = lo;
		end else if (acc_s5 > hi) begin
			clipped = hi;
		end else begin
			clipped = acc_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s5 <= mb.valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s5    <= val;
			qp_s5     <= mb.qp_used;
			scaled_s6 <= clipped[ResW-1:0];
			qp_s6     <= qp_s5;
		end
	end

	assign res.valid        = v_s6;
	assign res.scaled_coeff = scaled_s6;
	assign res.qp_used      = qp_s6;

endmodule

@@ design/transform_coefficient_dequantizer_core.sv @@
// Top level of the transform coefficient dequantizer: config registers and pipeline.
// Usage:
//   din  carries one quantized coefficient per beat with its block's qp, component,
//        transform-skip and colour-transform flags, log2 sizes and scaling entry.
//   dout carries one beat per input beat: the clipped coefficient and the clipped
//        qp that was applied, in input order.
//   cfg  writes one register per beat (index, data); it is always ready. Write only
//        while no beat is in flight; the pipeline reads the registers live.
// Timing:
//   Six register stages: qp forming, qp div/mod 6, level-scale products, coefficient
//   multiply, rounding shift, clip into the output register. A beat passes them in that
//   order and is held in the output register until dout takes it. One beat per cycle
//   sustained while dout takes every beat; the 16x16 coefficient multiply and the
//   53-bit shift of the rounding stage set the clock period.
// Stall:
//   All stages advance together when the output register is empty or taken. While
//   dout holds a beat that is not taken, din.ready drops and every stage holds.
// Reset:
//   arst_n clears the stage valid bits and loads the register defaults (bit depth 8,
//   range log2 15, all others 0). The first beat can be taken in the cycle after.
`include "transform_coefficient_dequantizer_core_macros.svh"

module transform_coefficient_dequantizer_core
	import tcdq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	tcdq_in_if.sink    din,
	tcdq_out_if.source dout,
	tcdq_cfg_if.sink   cfg
);

	logic [BdW-1:0]   bd_q;
	logic [RngW-1:0]  rng_q;
	logic [OffW-1:0]  off_q;
	logic [SkipW-1:0] skip_q;
	logic             dq_q;

	cfg_t     cfg_now;
	item_t    item;
	qp_bus_t  qb;
	mul_bus_t mb;
	res_t     res;
	logic     adv;

	// register file; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bd_q   <= BdW'(8);
			rng_q  <= RngW'(15);
			off_q  <= '0;
			skip_q <= '0;
			dq_q   <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CfgSampleBitDepth: bd_q   <= cfg.data[BdW-1:0];
				CfgCoeffRangeLog2: rng_q  <= cfg.data[RngW-1:0];
				CfgQpDepthOffset:  off_q  <= cfg.data[OffW-1:0];
				CfgSkipMinQpCode:  skip_q <= cfg.data[SkipW-1:0];
				CfgDepQuantEnable: dq_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	assign cfg_now.sample_bit_depth  = bd_q;
	assign cfg_now.coeff_range_log2  = rng_q;
	assign cfg_now.qp_depth_offset   = off_q;
	assign cfg_now.skip_min_qp_code  = skip_q;
	assign cfg_now.dep_quant_enabled = dq_q;

	// advance the whole pipe whenever the output register frees up
	assign adv       = !res.valid || dout.ready;
	assign din.ready = adv;

	assign item.coeff          = din.coeff;
	assign item.scale_factor   = din.scale_factor;
	assign item.qp_in          = din.qp_in;
	assign item.is_chroma      = din.is_chroma;
	assign item.transform_skip = din.transform_skip;
	assign item.act_enabled    = din.act_enabled;
	assign item.log2_width     = din.log2_width;
	assign item.log2_height    = din.log2_height;

	tcdq_qp u_qp (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_now),
		.in_valid (din.valid),
		.item     (item),
		.bus      (qb)
	);

	tcdq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.qb     (qb),
		.mb     (mb)
	);

	tcdq_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.cfg    (cfg_now),
		.mb     (mb),
		.res    (res)
	);

	assign dout.valid        = res.valid;
	assign dout.scaled_coeff = res.scaled_coeff;
	assign dout.qp_used      = res.qp_used;

	// checks
	logic [QpW-1:0]     qp_cap;
	logic [QpW-1:0]     ts_floor;
	logic [RngW-1:0]    rng_eff;
	logic signed [ResW:0] lim_hi;
	logic signed [ResW:0] lim_lo;
	logic signed [ResW:0] out_wide;

	assign qp_cap   = QpW'(QpMaxBase) + {1'b0, off_q};
	assign ts_floor = QpW'(TsMinBase) + QpW'(TsMinStep) * {3'b000, skip_q};
	assign rng_eff  = clip_rng(rng_q);
	assign lim_hi   = $signed((ResW+1)'(1) << rng_eff) - $signed((ResW+1)'(1));
	assign lim_lo   = -$signed((ResW+1)'(1) << rng_eff);
	assign out_wide = $signed({dout.scaled_coeff[ResW-1], dout.scaled_coeff});

	`TCDQ_ASSERT_SAME(a_stall_blocks_input, clk, arst_n,
		dout.valid && !dout.ready, !din.ready, "input taken while output stalled")
	`TCDQ_ASSERT_NEXT(a_stall_freezes_pipe, clk, arst_n,
		dout.valid && !dout.ready && mb.valid, mb.valid && $stable(mb.prod),
		"multiply stage moved during a stall")
	`TCDQ_ASSERT_SAME(a_coeff_in_range, clk, arst_n,
		dout.valid, out_wide >= lim_lo && out_wide <= lim_hi,
		"scaled coefficient outside clip range")
	`TCDQ_ASSERT_SAME(a_qp_bounded, clk, arst_n,
		dout.valid, dout.qp_used <= qp_cap || dout.qp_used <= ts_floor,
		"qp above both bounds")

endmodule
